// File: rtl/core/cgs_pkg.sv
// Package for the curve grid snapper: item types, register indexes, and the
// command and status groups between the controller and the datapath.
// No dependencies.
package cgs_pkg;

    // Default curve length in cells.
    localparam int MAX_POINTS_DEF = 64;

    // Fixed field widths.
    localparam int COORD_W    = 32;
    localparam int CELL_W     = 32;
    localparam int OFFSET_W   = 31;
    localparam int INV_W      = 32;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int PROD_W     = 64;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INV_CELL_SIZE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_COORD     = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [OFFSET_W-1:0] OFFSET_RST = '0;
    localparam logic [INV_W-1:0]    INV_RST    = 32'd65536;
    localparam logic [COORD_W-1:0]  MAXC_RST   = '0;

    // One input item.
    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic                      last_point;
    } in_item_t;

    // One result item.
    typedef struct packed {
        logic signed [CELL_W-1:0] cell_x;
        logic signed [CELL_W-1:0] cell_y;
        logic                     is_padding;
        logic                     end_of_curve;
        logic                     overflowed;
    } out_item_t;

    // Destination of one snap operation.
    typedef enum logic [1:0] {
        DST_X,
        DST_Y,
        DST_PX,
        DST_PY
    } snap_dst_t;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ISSUE_X,
        ST_ISSUE_Y,
        ST_ISSUE_PX,
        ST_ISSUE_PY,
        ST_WAIT,
        ST_DEDUP,
        ST_FINAL,
        ST_PAD
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      load_point;
        logic      issue;
        snap_dst_t issue_dst;
        logic      load_held;
        logic      emit;
        logic      emit_pad;
        logic      emit_eoc;
        logic      cnt_inc;
        logic      set_ovf;
        logic      clear_curve;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pipe_busy;
        logic held_valid;
        logic cell_diff;
        logic cnt_at_cap;
        logic out_free;
    } dp_stat_t;

endpackage

// File: rtl/core/cgs_snap.sv
// Snap unit: offset subtract, multiply by reciprocal cell size, round half
// away from zero and saturate. Three steps, one operation issued per cycle.
// Depends on cgs_pkg.
module cgs_snap (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    input  cgs_pkg::snap_dst_t                in_dst,
    input  logic signed [cgs_pkg::COORD_W-1:0] in_coord,
    input  logic [cgs_pkg::OFFSET_W-1:0]      in_offset,
    input  logic [cgs_pkg::INV_W-1:0]         in_inv,
    output logic                              out_valid,
    output cgs_pkg::snap_dst_t                out_dst,
    output logic [cgs_pkg::CELL_W-1:0]        out_cell,
    output logic                              busy
);

    logic signed [cgs_pkg::COORD_W:0] diff;
    logic signed [cgs_pkg::COORD_W:0] neg_diff;
    logic [cgs_pkg::COORD_W-1:0]      mag;

    logic                             s1_valid_reg;
    cgs_pkg::snap_dst_t               s1_dst_reg;
    logic [cgs_pkg::COORD_W-1:0]      s1_mag_reg;
    logic                             s1_neg_reg;

    logic                             s2_valid_reg;
    cgs_pkg::snap_dst_t               s2_dst_reg;
    logic [cgs_pkg::PROD_W-1:0]       s2_prod_reg;
    logic                             s2_neg_reg;

    logic [cgs_pkg::PROD_W:0]         rnd_sum;
    logic [cgs_pkg::CELL_W:0]         idx;

    // Signed difference and its magnitude; the magnitude always fits 32 bits.
    always_comb begin
        diff     = {in_coord[cgs_pkg::COORD_W-1], in_coord}
                 - $signed({2'b00, in_offset});
        neg_diff = -diff;
        mag      = diff[cgs_pkg::COORD_W] ? neg_diff[cgs_pkg::COORD_W-1:0]
                                          : diff[cgs_pkg::COORD_W-1:0];
    end

    // Valid flags of the two stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // Stage payloads: magnitude, then the full 64-bit product.
    always_ff @(posedge aclk) begin
        s1_dst_reg  <= in_dst;
        s1_mag_reg  <= mag;
        s1_neg_reg  <= diff[cgs_pkg::COORD_W];
        s2_dst_reg  <= s1_dst_reg;
        s2_neg_reg  <= s1_neg_reg;
        s2_prod_reg <= cgs_pkg::PROD_W'(s1_mag_reg) * cgs_pkg::PROD_W'(in_inv);
    end

    // Round half away from zero, apply the sign and saturate.
    always_comb begin
        rnd_sum = {1'b0, s2_prod_reg} + 65'h0_8000_0000;
        idx     = rnd_sum[cgs_pkg::PROD_W:cgs_pkg::PROD_W-cgs_pkg::CELL_W];
        if (s2_neg_reg) begin
            if (idx >= 33'h0_8000_0000) begin
                out_cell = 32'h8000_0000;
            end else begin
                out_cell = 32'h0 - idx[cgs_pkg::CELL_W-1:0];
            end
        end else begin
            if (idx > 33'h0_7FFF_FFFF) begin
                out_cell = 32'h7FFF_FFFF;
            end else begin
                out_cell = idx[cgs_pkg::CELL_W-1:0];
            end
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_dst   = s2_dst_reg;
    assign busy      = s1_valid_reg | s2_valid_reg;

endmodule

// File: rtl/core/cgs_datapath.sv
// Datapath: configuration registers, point register, snap unit, held cell,
// per-curve counters and the output register.
// Depends on cgs_pkg and cgs_snap.
module cgs_datapath #(
    parameter int MAX_POINTS = cgs_pkg::MAX_POINTS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [cgs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cgs_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  cgs_pkg::in_item_t                 s_data,
    input  logic                              m_ready,
    output logic                              m_valid,
    output cgs_pkg::out_item_t                m_data,
    input  cgs_pkg::dp_cmd_t                  cmd,
    output cgs_pkg::dp_stat_t                 stat
);

    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    logic [cgs_pkg::OFFSET_W-1:0] offset_x_reg;
    logic [cgs_pkg::OFFSET_W-1:0] offset_y_reg;
    logic [cgs_pkg::INV_W-1:0]    inv_reg;
    logic [cgs_pkg::COORD_W-1:0]  max_coord_reg;

    cgs_pkg::in_item_t            point_reg;

    logic signed [cgs_pkg::COORD_W-1:0] snap_coord;
    logic [cgs_pkg::OFFSET_W-1:0]       snap_offset;
    logic                               snap_valid;
    cgs_pkg::snap_dst_t                 snap_dst;
    logic [cgs_pkg::CELL_W-1:0]         snap_cell;
    logic                               snap_busy;

    logic [cgs_pkg::CELL_W-1:0] cx_reg;
    logic [cgs_pkg::CELL_W-1:0] cy_reg;
    logic [cgs_pkg::CELL_W-1:0] px_reg;
    logic [cgs_pkg::CELL_W-1:0] py_reg;

    logic [cgs_pkg::CELL_W-1:0] held_x_reg;
    logic [cgs_pkg::CELL_W-1:0] held_y_reg;
    logic                       held_valid_reg;
    logic [CNT_W-1:0]           count_reg;
    logic                       ovf_reg;

    logic                       m_valid_reg;
    cgs_pkg::out_item_t         m_data_reg;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_x_reg  <= cgs_pkg::OFFSET_RST;
            offset_y_reg  <= cgs_pkg::OFFSET_RST;
            inv_reg       <= cgs_pkg::INV_RST;
            max_coord_reg <= cgs_pkg::MAXC_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                cgs_pkg::REG_OFFSET_X:      offset_x_reg  <= cfg_wdata[cgs_pkg::OFFSET_W-1:0];
                cgs_pkg::REG_OFFSET_Y:      offset_y_reg  <= cfg_wdata[cgs_pkg::OFFSET_W-1:0];
                cgs_pkg::REG_INV_CELL_SIZE: inv_reg       <= cfg_wdata[cgs_pkg::INV_W-1:0];
                cgs_pkg::REG_MAX_COORD:     max_coord_reg <= cfg_wdata[cgs_pkg::COORD_W-1:0];
                default: ;
            endcase
        end
    end

    // Point register, loaded when a transaction is accepted.
    always_ff @(posedge aclk) begin
        if (cmd.load_point) begin
            point_reg <= s_data;
        end
    end

    // Operand selection for the snap unit.
    always_comb begin
        case (cmd.issue_dst)
            cgs_pkg::DST_X: begin
                snap_coord  = point_reg.point_x;
                snap_offset = offset_x_reg;
            end
            cgs_pkg::DST_Y: begin
                snap_coord  = point_reg.point_y;
                snap_offset = offset_y_reg;
            end
            cgs_pkg::DST_PX: begin
                snap_coord  = $signed(max_coord_reg);
                snap_offset = offset_x_reg;
            end
            cgs_pkg::DST_PY: begin
                snap_coord  = $signed(max_coord_reg);
                snap_offset = offset_y_reg;
            end
            default: begin
                snap_coord  = point_reg.point_x;
                snap_offset = offset_x_reg;
            end
        endcase
    end

    cgs_snap u_snap (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (cmd.issue),
        .in_dst    (cmd.issue_dst),
        .in_coord  (snap_coord),
        .in_offset (snap_offset),
        .in_inv    (inv_reg),
        .out_valid (snap_valid),
        .out_dst   (snap_dst),
        .out_cell  (snap_cell),
        .busy      (snap_busy)
    );

    // Capture snapped cells into their destination registers.
    always_ff @(posedge aclk) begin
        if (snap_valid) begin
            case (snap_dst)
                cgs_pkg::DST_X:  cx_reg <= snap_cell;
                cgs_pkg::DST_Y:  cy_reg <= snap_cell;
                cgs_pkg::DST_PX: px_reg <= snap_cell;
                cgs_pkg::DST_PY: py_reg <= snap_cell;
                default: ;
            endcase
        end
    end

    // Held cell and per-curve counters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_x_reg     <= '0;
            held_y_reg     <= '0;
            held_valid_reg <= 1'b0;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
        end else begin
            if (cmd.load_held) begin
                held_x_reg <= cx_reg;
                held_y_reg <= cy_reg;
            end
            if (cmd.clear_curve) begin
                held_valid_reg <= 1'b0;
                count_reg      <= '0;
                ovf_reg        <= 1'b0;
            end else begin
                if (cmd.load_held) begin
                    held_valid_reg <= 1'b1;
                end
                if (cmd.cnt_inc) begin
                    count_reg <= count_reg + CNT_W'(1);
                end
                if (cmd.set_ovf) begin
                    ovf_reg <= 1'b1;
                end
            end
        end
    end

    // Output register valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Output register payload: held cell or padding cell.
    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_data_reg.cell_x       <= cmd.emit_pad ? px_reg : held_x_reg;
            m_data_reg.cell_y       <= cmd.emit_pad ? py_reg : held_y_reg;
            m_data_reg.is_padding   <= cmd.emit_pad;
            m_data_reg.end_of_curve <= cmd.emit_eoc;
            m_data_reg.overflowed   <= ovf_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Status toward the controller.
    always_comb begin
        stat.pipe_busy  = snap_busy;
        stat.held_valid = held_valid_reg;
        stat.cell_diff  = (cx_reg != held_x_reg) || (cy_reg != held_y_reg);
        stat.cnt_at_cap = count_reg >= CNT_W'(MAX_POINTS - 1);
        stat.out_free   = !m_valid_reg || m_ready;
    end

endmodule

// File: rtl/core/cgs_ctrl.sv
// Controller state machine: sequences the snap operations, the duplicate
// check, and the end-of-curve burst of held and padding cells.
// Depends on cgs_pkg.
module cgs_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_last,
    output logic              s_ready,
    input  cgs_pkg::dp_stat_t stat,
    output cgs_pkg::dp_cmd_t  cmd
);

    cgs_pkg::ctrl_state_t state_reg;
    cgs_pkg::ctrl_state_t state_next;
    logic                 last_reg;
    logic                 last_next;

    // State register and last-point flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cgs_pkg::ST_IDLE;
            last_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            last_reg  <= last_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        last_next  = last_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        case (state_reg)
            cgs_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_point = 1'b1;
                    last_next      = s_last;
                    state_next     = cgs_pkg::ST_ISSUE_X;
                end
            end
            cgs_pkg::ST_ISSUE_X: begin
                cmd.issue     = 1'b1;
                cmd.issue_dst = cgs_pkg::DST_X;
                state_next    = cgs_pkg::ST_ISSUE_Y;
            end
            cgs_pkg::ST_ISSUE_Y: begin
                cmd.issue     = 1'b1;
                cmd.issue_dst = cgs_pkg::DST_Y;
                state_next    = last_reg ? cgs_pkg::ST_ISSUE_PX : cgs_pkg::ST_WAIT;
            end
            cgs_pkg::ST_ISSUE_PX: begin
                cmd.issue     = 1'b1;
                cmd.issue_dst = cgs_pkg::DST_PX;
                state_next    = cgs_pkg::ST_ISSUE_PY;
            end
            cgs_pkg::ST_ISSUE_PY: begin
                cmd.issue     = 1'b1;
                cmd.issue_dst = cgs_pkg::DST_PY;
                state_next    = cgs_pkg::ST_WAIT;
            end
            cgs_pkg::ST_WAIT: begin
                if (!stat.pipe_busy) begin
                    state_next = cgs_pkg::ST_DEDUP;
                end
            end
            cgs_pkg::ST_DEDUP: begin
                // A new distinct cell releases the held one, capacity allowing.
                if (!stat.held_valid) begin
                    cmd.load_held = 1'b1;
                    state_next    = last_reg ? cgs_pkg::ST_FINAL : cgs_pkg::ST_IDLE;
                end else if (stat.cell_diff && !stat.cnt_at_cap) begin
                    if (stat.out_free) begin
                        cmd.emit      = 1'b1;
                        cmd.cnt_inc   = 1'b1;
                        cmd.load_held = 1'b1;
                        state_next    = last_reg ? cgs_pkg::ST_FINAL : cgs_pkg::ST_IDLE;
                    end
                end else if (stat.cell_diff) begin
                    cmd.set_ovf   = 1'b1;
                    cmd.load_held = 1'b1;
                    state_next    = last_reg ? cgs_pkg::ST_FINAL : cgs_pkg::ST_IDLE;
                end else begin
                    state_next = last_reg ? cgs_pkg::ST_FINAL : cgs_pkg::ST_IDLE;
                end
            end
            cgs_pkg::ST_FINAL: begin
                if (stat.out_free) begin
                    cmd.emit     = 1'b1;
                    cmd.emit_eoc = stat.cnt_at_cap;
                    cmd.cnt_inc  = 1'b1;
                    if (stat.cnt_at_cap) begin
                        cmd.clear_curve = 1'b1;
                        state_next      = cgs_pkg::ST_IDLE;
                    end else begin
                        state_next = cgs_pkg::ST_PAD;
                    end
                end
            end
            cgs_pkg::ST_PAD: begin
                if (stat.out_free) begin
                    cmd.emit     = 1'b1;
                    cmd.emit_pad = 1'b1;
                    cmd.emit_eoc = stat.cnt_at_cap;
                    cmd.cnt_inc  = 1'b1;
                    if (stat.cnt_at_cap) begin
                        cmd.clear_curve = 1'b1;
                        state_next      = cgs_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = cgs_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/curve_grid_snapper.sv
// Curve grid snapper top level. A point is accepted only once the previous
// one is finished; a last point is also followed by its end-of-curve cells
// (held cell and padding, up to MAX_POINTS in all). The three-step snap unit
// has a single multiplier that serves x, y and padding.
// Reset (aresetn, synchronous, active low) restores the configuration registers
// to their defaults and starts a fresh curve with nothing held.
module curve_grid_snapper #(
    parameter int MAX_POINTS = cgs_pkg::MAX_POINTS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [cgs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cgs_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  cgs_pkg::in_item_t              s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output cgs_pkg::out_item_t             m_data
);

    cgs_pkg::dp_cmd_t  cmd;
    cgs_pkg::dp_stat_t stat;

    // Controller.
    cgs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_last  (s_data.last_point),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Datapath.
    cgs_datapath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule
